// ===== rtl/sm83_pkg.sv =====
package sm83_pkg;

  // Register codes of the standard operand encoding. Slot 6 holds F.
  localparam int unsigned NumRegs  = 8;
  localparam int unsigned RegIdxW  = 3;
  localparam int unsigned PairIdxW = 2;
  localparam int unsigned BankDepth = NumRegs / 2;

  // Pair codes, which are also the addresses of both register banks.
  localparam logic [PairIdxW-1:0] PairBC = 2'd0;
  localparam logic [PairIdxW-1:0] PairDE = 2'd1;
  localparam logic [PairIdxW-1:0] PairHL = 2'd2;
  localparam logic [PairIdxW-1:0] PairAF = 2'd3;
  localparam logic [PairIdxW-1:0] PairSP = 2'd3;

  localparam logic [RegIdxW-1:0] RegHlInd = 3'd6;

  localparam logic [7:0] OpHalt    = 8'h76;
  localparam logic [7:0] OpLogicLo = 8'hA0;
  localparam logic [7:0] OpLogicHi = 8'hB7;

  localparam logic [7:0] FlagZ = 8'h80;
  localparam logic [7:0] FlagH = 8'h20;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ILLEGAL = 2'd1,
    ST_UNIMPL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    K_NONE,
    K_LD16,
    K_LDI8,
    K_LDRR,
    K_LDRM,
    K_STHL,
    K_LOGIC
  } kind_e;

  typedef enum logic [1:0] {
    LOP_AND = 2'd0,
    LOP_XOR = 2'd1,
    LOP_OR  = 2'd2,
    LOP_CP  = 2'd3
  } lop_e;

  typedef struct packed {
    status_e     status;
    logic [1:0]  len;
    logic [3:0]  cyc;
    kind_e       kind;
  } dec_t;

  // Write-back that took place at the edge where the register banks were read.
  typedef struct packed {
    logic                we_ev;
    logic                we_od;
    logic [PairIdxW-1:0] addr;
    logic [7:0]          d_ev;
    logic [7:0]          d_od;
  } fwd_t;

  function automatic logic is_illegal(input logic [7:0] op);
    logic r;
    case (op)
      8'hD3, 8'hDB, 8'hDD, 8'hE3, 8'hE4, 8'hEB,
      8'hEC, 8'hED, 8'hF4, 8'hFC, 8'hFD: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic dec_t sm83_decode(input logic [7:0] op);
    dec_t d;
    d.status = ST_UNIMPL;
    d.len    = 2'd1;
    d.cyc    = 4'd0;
    d.kind   = K_NONE;
    if (is_illegal(op)) begin
      d.status = ST_ILLEGAL;
    end else if ((op & 8'hCF) == 8'h01) begin
      d.status = ST_OK; d.len = 2'd3; d.cyc = 4'd12; d.kind = K_LD16;
    end else if (((op & 8'hC7) == 8'h06) && (op[5:3] != RegHlInd)) begin
      d.status = ST_OK; d.len = 2'd2; d.cyc = 4'd8; d.kind = K_LDI8;
    end else if ((op[7:6] == 2'b01) && (op != OpHalt)) begin
      d.status = ST_OK;
      if (op[5:3] == RegHlInd) begin
        d.cyc = 4'd8; d.kind = K_STHL;
      end else if (op[2:0] == RegHlInd) begin
        d.cyc = 4'd8; d.kind = K_LDRM;
      end else begin
        d.cyc = 4'd4; d.kind = K_LDRR;
      end
    end else if ((op >= OpLogicLo) && (op <= OpLogicHi) && (op[2:0] != RegHlInd)) begin
      d.status = ST_OK; d.cyc = 4'd4; d.kind = K_LOGIC;
    end
    return d;
  endfunction

endpackage

// ===== rtl/sm83_in_if.sv =====
interface sm83_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] opcode_byte;
  logic [7:0] imm_first;
  logic [7:0] imm_second;
  logic [7:0] hl_data;

  modport source (output valid, opcode_byte, imm_first, imm_second, hl_data,
                  input ready);
  modport sink   (input valid, opcode_byte, imm_first, imm_second, hl_data,
                  output ready);
endinterface

// ===== rtl/sm83_out_if.sv =====
interface sm83_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [1:0]  length;
  logic [3:0]  cycle_count;
  logic        mem_write;
  logic [15:0] mem_addr;
  logic [7:0]  mem_wdata;
  logic [7:0]  acc_out;
  logic [7:0]  flags_out;
  logic [15:0] hl_out;
  logic [15:0] pc_out;

  modport source (output valid, status, length, cycle_count, mem_write, mem_addr,
                  mem_wdata, acc_out, flags_out, hl_out, pc_out,
                  input ready);
  modport sink   (input valid, status, length, cycle_count, mem_write, mem_addr,
                  mem_wdata, acc_out, flags_out, hl_out, pc_out,
                  output ready);
endinterface

// ===== rtl/sm83_ram.sv =====
module sm83_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sm83_load_logic_execute.sv =====
// A request accepted at one edge waits in the execute stage; its result is
// registered when that stage advances. Throughput: one instruction per
// cycle while the output is not stalled; the register banks are read at
// the accept edge and written back when the instruction leaves the execute
// stage, with a forward path for a write-back on the same edge as the read.
// Reset: all registers, SP and PC read as zero; valid bits stand in for
// clearing the bank memories, so requests are taken right after reset.
module sm83_load_logic_execute
  import sm83_pkg::*;
(
  input logic           clk_i,
  input logic           rst_ni,
  sm83_in_if.sink       req_i,
  sm83_out_if.source    rsp_o
);

  // Execute stage
  logic        s1_valid_q;
  logic [7:0]  op_q, lo_q, hi_q, mem_q;
  logic        s1_adv, in_fire;

  // Architectural mirrors for outputs and the ALU, plus SP and PC
  logic [7:0]  a_q, f_q, h_q, l_q;
  logic [15:0] sp_q, pc_q;
  logic [NumRegs-1:0] vld_q;
  fwd_t        fwd_q, fwd_d;

  // Result register
  logic        out_valid_q;
  status_e     status_q;
  logic [1:0]  len_q;
  logic [3:0]  cyc_q;
  logic        wr_q;
  logic [15:0] maddr_q, hl_out_q, pc_out_q;
  logic [7:0]  wdata_q, acc_q, flags_q;

  logic [7:0]  ev_rdata, od_rdata;
  dec_t        dec;
  logic [RegIdxW-1:0] src, dst;
  logic        fwd_hit;
  logic [7:0]  ram_sel, src_dat;
  logic [7:0]  alu_res, alu_flags;
  logic        ev_we, od_we, sp_we;
  logic [PairIdxW-1:0] wa;
  logic [7:0]  ev_d, od_d;
  logic [7:0]  a_n, f_n, h_n, l_n;

  assign s1_adv  = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign in_fire = req_i.valid && req_i.ready;

  // Even bank: B D H F. Odd bank: C E L A.
  sm83_ram #(.Width(8), .Depth(BankDepth)) u_bank_ev (
    .clk_i   (clk_i),
    .we_i    (ev_we),
    .waddr_i (wa),
    .wdata_i (ev_d),
    .re_i    (in_fire),
    .raddr_i (req_i.opcode_byte[2:1]),
    .rdata_o (ev_rdata)
  );

  sm83_ram #(.Width(8), .Depth(BankDepth)) u_bank_od (
    .clk_i   (clk_i),
    .we_i    (od_we),
    .waddr_i (wa),
    .wdata_i (od_d),
    .re_i    (in_fire),
    .raddr_i (req_i.opcode_byte[2:1]),
    .rdata_o (od_rdata)
  );

  assign dec = sm83_decode(op_q);
  assign src = op_q[2:0];
  assign dst = op_q[5:3];

  always_comb begin
    ram_sel = src[0] ? od_rdata : ev_rdata;
    fwd_hit = (fwd_q.addr == src[2:1]) && (src[0] ? fwd_q.we_od : fwd_q.we_ev);
    if (fwd_hit) begin
      src_dat = src[0] ? fwd_q.d_od : fwd_q.d_ev;
    end else if (vld_q[src]) begin
      src_dat = ram_sel;
    end else begin
      src_dat = '0;
    end
  end

  always_comb begin
    alu_res = a_q & src_dat;
    case (lop_e'(op_q[4:3]))
      LOP_AND: alu_res = a_q & src_dat;
      LOP_XOR: alu_res = a_q ^ src_dat;
      LOP_OR:  alu_res = a_q | src_dat;
      default: alu_res = a_q & src_dat;
    endcase
    alu_flags = (lop_e'(op_q[4:3]) == LOP_AND) ? FlagH : 8'h00;
    if (alu_res == 8'h00) begin
      alu_flags = alu_flags | FlagZ;
    end
  end

  always_comb begin
    logic ev_w, od_w;
    ev_w  = 1'b0;
    od_w  = 1'b0;
    sp_we = 1'b0;
    wa    = dst[2:1];
    ev_d  = lo_q;
    od_d  = lo_q;
    case (dec.kind)
      K_LD16: begin
        wa = op_q[5:4];
        ev_d = hi_q;
        od_d = lo_q;
        if (op_q[5:4] == PairSP) begin
          sp_we = 1'b1;
        end else begin
          ev_w = 1'b1;
          od_w = 1'b1;
        end
      end
      K_LDI8: begin
        ev_w = !dst[0];
        od_w = dst[0];
      end
      K_LDRR: begin
        ev_w = !dst[0];
        od_w = dst[0];
        ev_d = src_dat;
        od_d = src_dat;
      end
      K_LDRM: begin
        ev_w = !dst[0];
        od_w = dst[0];
        ev_d = mem_q;
        od_d = mem_q;
      end
      K_LOGIC: begin
        wa = PairAF;
        ev_w = 1'b1;
        od_w = 1'b1;
        ev_d = alu_flags;
        od_d = alu_res;
      end
      default: begin
        ev_w = 1'b0;
        od_w = 1'b0;
      end
    endcase
    ev_we = ev_w && s1_adv;
    od_we = od_w && s1_adv;
    sp_we = sp_we && s1_adv;
  end

  always_comb begin
    a_n = (od_we && (wa == PairAF)) ? od_d : a_q;
    f_n = (ev_we && (wa == PairAF)) ? ev_d : f_q;
    h_n = (ev_we && (wa == PairHL)) ? ev_d : h_q;
    l_n = (od_we && (wa == PairHL)) ? od_d : l_q;
    fwd_d.we_ev = ev_we;
    fwd_d.we_od = od_we;
    fwd_d.addr  = wa;
    fwd_d.d_ev  = ev_d;
    fwd_d.d_od  = od_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      a_q   <= '0;
      f_q   <= '0;
      h_q   <= '0;
      l_q   <= '0;
      sp_q  <= '0;
      pc_q  <= '0;
      vld_q <= '0;
      fwd_q <= '0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      a_q <= a_n;
      f_q <= f_n;
      h_q <= h_n;
      l_q <= l_n;
      if (sp_we) begin
        sp_q <= {hi_q, lo_q};
      end
      if (s1_adv) begin
        pc_q <= pc_q + 16'(dec.len);
      end
      if (ev_we) begin
        vld_q[{wa, 1'b0}] <= 1'b1;
      end
      if (od_we) begin
        vld_q[{wa, 1'b1}] <= 1'b1;
      end
      // Only a write-back on the read edge can be missed by the banks.
      if (in_fire) begin
        fwd_q <= fwd_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= req_i.opcode_byte;
      lo_q  <= req_i.imm_first;
      hi_q  <= req_i.imm_second;
      mem_q <= req_i.hl_data;
    end
    if (s1_adv) begin
      status_q <= dec.status;
      len_q    <= dec.len;
      cyc_q    <= dec.cyc;
      wr_q     <= (dec.kind == K_STHL);
      maddr_q  <= {h_q, l_q};
      wdata_q  <= (dec.kind == K_STHL) ? src_dat : 8'h00;
      acc_q    <= a_n;
      flags_q  <= f_n;
      hl_out_q <= {h_n, l_n};
      pc_out_q <= pc_q + 16'(dec.len);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.length      = len_q;
  assign rsp_o.cycle_count = cyc_q;
  assign rsp_o.mem_write   = wr_q;
  assign rsp_o.mem_addr    = maddr_q;
  assign rsp_o.mem_wdata   = wdata_q;
  assign rsp_o.acc_out     = acc_q;
  assign rsp_o.flags_out   = flags_q;
  assign rsp_o.hl_out      = hl_out_q;
  assign rsp_o.pc_out      = pc_out_q;

endmodule

// ===== rtl/sm83_chk.sv =====
module sm83_chk
  import sm83_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  status_i,
  input logic [1:0]  length_i,
  input logic [3:0]  cycle_count_i,
  input logic        mem_write_i,
  input logic [7:0]  flags_i,
  input logic [15:0] pc_i
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(pc_i) && $stable(status_i))
    else $error("Result changed while stalled.");

  a_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_OK) |-> (length_i == 2'd1) && (cycle_count_i == 4'd0)
      && !mem_write_i && (flags_i[3:0] == 4'h0))
    else $error("Rejected instruction reported work.");

  a_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && mem_write_i |-> (status_i == ST_OK) && (cycle_count_i == 4'd8)
      && (length_i == 2'd1))
    else $error("Store with wrong timing.");

  a_len3: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (length_i == 2'd3) |-> (cycle_count_i == 4'd12) && (status_i == ST_OK))
    else $error("Three-byte instruction with wrong cycle count.");

endmodule

bind sm83_load_logic_execute sm83_chk u_sm83_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .status_i      (rsp_o.status),
  .length_i      (rsp_o.length),
  .cycle_count_i (rsp_o.cycle_count),
  .mem_write_i   (rsp_o.mem_write),
  .flags_i       (rsp_o.flags_out),
  .pc_i          (rsp_o.pc_out)
);
